/* hdl/stpt_pkg.sv */
// ----------------------------------------------------------------------------
// stpt_pkg
// Shared types and constants of the stepper axis position tracker.
// ----------------------------------------------------------------------------
package stpt_pkg;

   localparam int AXES     = 4;
   localparam int AXIS_W   = 2;
   localparam int KIND_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int RATE_W   = 31;
   localparam int AIU_W    = 3;
   localparam int MASK_W   = 4;
   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   localparam logic [RATE_W-1:0] SAT31 = {RATE_W{1'b1}};

   // command kind codes on the request side
   localparam logic [KIND_W-1:0] KIND_SET_POS = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SET_VEL = 3'd1;
   localparam logic [KIND_W-1:0] KIND_STEP    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_HALT    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ESTOP   = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_DRIVER_READY  = 2'd0;
   localparam logic [1:0] CSR_ATTACHED_MASK = 2'd1;
   localparam logic [1:0] CSR_AXES_IN_USE   = 2'd2;

   typedef enum logic [2:0] {
      OP_SET_POS,
      OP_SET_VEL,
      OP_STEP,
      OP_HALT,
      OP_ESTOP,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [AXIS_W-1:0]         axis;
      logic signed [VALUE_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic              driver_ready;
      logic [MASK_W-1:0] attached_mask;
      logic [AIU_W-1:0]  axes_in_use;
   } cfg_type;

   typedef struct packed {
      logic [AXIS_W-1:0]         axis_out;
      logic                      accepted;
      logic                      rate_valid;
      logic [RATE_W-1:0]         rate;
      logic                      forward;
      logic                      keep_stepping;
      logic signed [VALUE_W-1:0] position;
      logic                      last;
   } result_type;

endpackage

/* hdl/stepper_axis_position_tracker_unit.sv */
// ----------------------------------------------------------------------------
// stepper_axis_position_tracker_unit
// Motion state of up to four step/dir axes: targets, velocity, step
// accounting and emergency stop, with a short command queue in front.
//
//   channel  dir  handshake           payload
//   req      in   tvalid/tready       tuser kind, tdata axis+value
//   rsp      out  tvalid/tready       tdata result, tlast last result
//   csr      in   write enable only   index, wdata
//
// Set position and set velocity taken with the driver ready, and halt, on an
// attached axis pass from queue head through the calculate, apply and emit states
// to the result register; other commands skip the apply state, and emergency stop
// goes from calculate to a sweep over each swept axis in turn. Emit and sweep wait on rsp_tready.
// Reset clears axis state and control registers at once; no clearing pass.
// A two-deep queue keeps intake open while execution waits on rsp_tready.
// ----------------------------------------------------------------------------
module stepper_axis_position_tracker_unit import stpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,    // kind[2:0]
   input  logic [39:0] req_tdata,    // axis[1:0], value[33:2], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // axis_out[1:0], accepted[2], rate_valid[3],
                                     // rate[34:4], forward[35], keep_stepping[36],
                                     // position[68:37], zero fill
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   cfg_type    cfg_ff;
   logic       q_full;
   logic       q_push;
   cmd_type    q_push_cmd;
   logic       q_pop;
   logic       q_not_empty;
   cmd_type    q_pop_cmd;
   result_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DRIVER_READY:  cfg_ff.driver_ready  <= csr_wdata[0];
            CSR_ATTACHED_MASK: cfg_ff.attached_mask <= csr_wdata[MASK_W-1:0];
            CSR_AXES_IN_USE:   cfg_ff.axes_in_use   <= csr_wdata[AIU_W-1:0];
            default: begin
            end
         endcase
      end
   end

   stpt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_axis   (req_tdata[1:0]),
      .req_value  (req_tdata[33:2]),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_push_cmd)
   );

   stpt_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_cmd   (q_pop_cmd)
   );

   stpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_not_empty),
      .q_cmd     (q_pop_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {3'b000, rsp.position, rsp.keep_stepping, rsp.forward,
                       rsp.rate, rsp.rate_valid, rsp.accepted, rsp.axis_out};
   assign rsp_tlast = rsp.last;

endmodule

/* hdl/stpt_front.sv */
// ----------------------------------------------------------------------------
// stpt_front
// Request intake: takes command beats and classifies them into operations.
// ----------------------------------------------------------------------------
module stpt_front import stpt_pkg::*; (
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [AXIS_W-1:0]   req_axis,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic                q_full,
   output logic                q_push,
   output cmd_type             q_cmd
);

   logic axis_ok;

   assign axis_ok    = 32'(req_axis) < AXES;
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

   always_comb begin
      q_cmd.axis  = req_axis;
      q_cmd.value = req_value;
      unique case (req_kind)
         KIND_SET_POS: q_cmd.op = OP_SET_POS;
         KIND_SET_VEL: q_cmd.op = OP_SET_VEL;
         KIND_STEP:    q_cmd.op = OP_STEP;
         KIND_HALT:    q_cmd.op = OP_HALT;
         KIND_ESTOP:   q_cmd.op = OP_ESTOP;
         default:      q_cmd.op = OP_BAD;
      endcase
      // axis range only matters for per-axis commands
      if (!axis_ok && req_kind != KIND_ESTOP) begin
         q_cmd.op = OP_BAD;
      end
   end

endmodule

/* hdl/stpt_cmd_queue.sv */
// ----------------------------------------------------------------------------
// stpt_cmd_queue
// Short FIFO of classified commands between intake and execution.
// ----------------------------------------------------------------------------
module stpt_cmd_queue import stpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_cmd
);

   cmd_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QDEPTH);
   assign not_empty = count_ff != '0;
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/stpt_back.sv */
// ----------------------------------------------------------------------------
// stpt_back
// Command execution: per-axis motion state, recompute, step accounting,
// emergency stop sweep and the result register.
// ----------------------------------------------------------------------------
module stpt_back import stpt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_APPLY,
      ST_EMIT,
      ST_SWEEP
   } state_type;

   localparam logic [1:0] DIR_IDLE = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   state_type                 state_ff;
   cmd_type                   cmd_ff;
   logic signed [VALUE_W-1:0] tpos_ff  [AXES];
   logic signed [VALUE_W-1:0] tvel_ff  [AXES];
   logic signed [VALUE_W-1:0] cpos_ff  [AXES];
   logic [RATE_W-1:0]         steps_ff [AXES];
   logic [1:0]                dir_ff   [AXES];
   logic [VALUE_W:0]          delta_ff;
   logic [RATE_W-1:0]         vmag_ff;
   logic                      vfwd_ff;
   result_type                res_ff;
   result_type                out_ff;
   logic                      out_valid_ff;
   logic [AXIS_W-1:0]         idx_ff;
   logic [AIU_W-1:0]          nsweep_ff;

   logic [AXIS_W-1:0]         ax;
   logic                      ax_ok;
   logic signed [VALUE_W-1:0] cur_pos;
   logic                      out_free;
   logic [AIU_W-1:0]          nsweep_in;
   // step accounting
   logic signed [VALUE_W-1:0] step_pos_in;
   logic [RATE_W-1:0]         step_left_in;
   logic                      keep_in;
   // target update and first half of recompute
   logic signed [VALUE_W-1:0] tpos_in;
   logic signed [VALUE_W-1:0] tvel_in;
   logic [VALUE_W:0]          delta_in;
   logic [VALUE_W-1:0]        vabs;
   logic [RATE_W-1:0]         vmag_in;
   // second half of recompute
   logic [VALUE_W:0]          dabs;
   logic [RATE_W-1:0]         apply_steps_in;
   logic [1:0]                apply_dir_in;
   logic [RATE_W-1:0]         apply_rate_in;
   logic                      apply_fwd_in;
   // sweep
   logic [AIU_W-1:0]          idx_next;
   logic                      sweep_last;

   assign ax       = cmd_ff.axis;
   assign ax_ok    = 32'(ax) < AXES;
   assign cur_pos  = ax_ok ? cpos_ff[ax] : '0;
   assign out_free = !out_valid_ff || rsp_ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   assign nsweep_in  = (cfg.axes_in_use > AIU_W'(AXES)) ? AIU_W'(AXES) : cfg.axes_in_use;
   assign idx_next   = AIU_W'(idx_ff) + AIU_W'(1);
   assign sweep_last = idx_next == nsweep_ff;

   always_comb begin
      step_pos_in  = cur_pos;
      step_left_in = steps_ff[ax];
      keep_in      = 1'b1;
      case (dir_ff[ax])
         DIR_FWD: step_pos_in = cur_pos + 32'sd1;
         DIR_REV: step_pos_in = cur_pos - 32'sd1;
         default: step_pos_in = cur_pos;
      endcase
      if (steps_ff[ax] != '0) begin
         step_left_in = steps_ff[ax] - RATE_W'(1);
         keep_in      = steps_ff[ax] != RATE_W'(1);
      end
   end

   always_comb begin
      tpos_in = tpos_ff[ax];
      tvel_in = tvel_ff[ax];
      case (cmd_ff.op)
         OP_SET_POS: tpos_in = cmd_ff.value;
         OP_SET_VEL: tvel_in = cmd_ff.value;
         default: begin
            tpos_in = cur_pos;
            tvel_in = '0;
         end
      endcase
      delta_in = {tpos_in[VALUE_W-1], tpos_in} - {cur_pos[VALUE_W-1], cur_pos};
      vabs     = tvel_in[VALUE_W-1] ? -tvel_in : tvel_in;
      // the most negative velocity leaves bit 31 set after negation
      vmag_in  = vabs[VALUE_W-1] ? SAT31 : vabs[RATE_W-1:0];
   end

   always_comb begin
      dabs           = delta_ff[VALUE_W] ? -delta_ff : delta_ff;
      apply_rate_in  = vmag_ff;
      apply_fwd_in   = vfwd_ff;
      apply_steps_in = '0;
      apply_dir_in   = DIR_IDLE;
      if (delta_ff != '0) begin
         // position target wins over velocity sign
         apply_fwd_in   = !delta_ff[VALUE_W];
         apply_steps_in = (dabs[VALUE_W:RATE_W] != '0) ? SAT31 : dabs[RATE_W-1:0];
         apply_dir_in   = apply_fwd_in ? DIR_FWD : DIR_REV;
      end else if (vmag_ff != '0) begin
         apply_dir_in   = vfwd_ff ? DIR_FWD : DIR_REV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
         nsweep_ff    <= '0;
         for (int i = 0; i < AXES; i++) begin
            tpos_ff[i]  <= '0;
            tvel_ff[i]  <= '0;
            cpos_ff[i]  <= '0;
            steps_ff[i] <= '0;
            dir_ff[i]   <= DIR_IDLE;
         end
      end else begin
         if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  cmd_ff   <= q_cmd;
                  state_ff <= ST_CALC;
               end
            end
            ST_CALC: begin
               res_ff.axis_out      <= ax;
               res_ff.accepted      <= 1'b0;
               res_ff.rate_valid    <= 1'b0;
               res_ff.rate          <= '0;
               res_ff.forward       <= 1'b0;
               res_ff.keep_stepping <= 1'b0;
               res_ff.position      <= cur_pos;
               res_ff.last          <= 1'b1;
               state_ff             <= ST_EMIT;
               unique case (cmd_ff.op)
                  OP_ESTOP: begin
                     idx_ff    <= '0;
                     nsweep_ff <= nsweep_in;
                     state_ff  <= (nsweep_in == '0) ? ST_IDLE : ST_SWEEP;
                  end
                  OP_STEP: begin
                     cpos_ff[ax]          <= step_pos_in;
                     steps_ff[ax]         <= step_left_in;
                     res_ff.accepted      <= keep_in;
                     res_ff.keep_stepping <= keep_in;
                     res_ff.position      <= step_pos_in;
                  end
                  OP_SET_POS, OP_SET_VEL, OP_HALT: begin
                     if (cmd_ff.op == OP_HALT || cfg.driver_ready) begin
                        tpos_ff[ax]     <= tpos_in;
                        tvel_ff[ax]     <= tvel_in;
                        delta_ff        <= delta_in;
                        vmag_ff         <= vmag_in;
                        vfwd_ff         <= !tvel_in[VALUE_W-1];
                        res_ff.accepted <= 1'b1;
                        if (cfg.attached_mask[ax]) begin
                           state_ff <= ST_APPLY;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            ST_APPLY: begin
               steps_ff[ax]      <= apply_steps_in;
               dir_ff[ax]        <= apply_dir_in;
               res_ff.rate_valid <= 1'b1;
               res_ff.rate       <= apply_rate_in;
               res_ff.forward    <= apply_fwd_in;
               state_ff          <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_ff       <= res_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SWEEP: begin
               if (out_free) begin
                  tvel_ff[idx_ff]      <= '0;
                  tpos_ff[idx_ff]      <= cpos_ff[idx_ff];
                  steps_ff[idx_ff]     <= '0;
                  dir_ff[idx_ff]       <= DIR_IDLE;
                  out_ff.axis_out      <= idx_ff;
                  out_ff.accepted      <= 1'b1;
                  out_ff.rate_valid    <= 1'b1;
                  out_ff.rate          <= '0;
                  out_ff.forward       <= 1'b1;
                  out_ff.keep_stepping <= 1'b0;
                  out_ff.position      <= cpos_ff[idx_ff];
                  out_ff.last          <= sweep_last;
                  out_valid_ff         <= 1'b1;
                  idx_ff               <= idx_ff + AXIS_W'(1);
                  if (sweep_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
